/* sv/sis_pkg.sv */
// Shared constants and types for the sorted insertion stack.
// Depends on nothing; imported by sis_cell, sorted_insertion_stack and tb_top.
`default_nettype none

package sis_pkg;

   localparam int DEPTH       = 16;
   localparam int VALUE_WIDTH = 32;
   localparam int COUNT_WIDTH = 5;

   localparam logic [1:0] OP_PUSH   = 2'd0;
   localparam logic [1:0] OP_POP    = 2'd1;
   localparam logic [1:0] OP_STATUS = 2'd2;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
   localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

   typedef logic signed [VALUE_WIDTH-1:0] value_type;

   // Broadcast from the controller to every cell.
   typedef struct packed {
      logic push;
      logic pop;
   } cell_ctrl_type;

endpackage

`default_nettype wire

/* sv/sis_cell.sv */
// One cell of the sorted chain: holds a single value and moves it towards
// or away from the top. Depends on sis_pkg.
`default_nettype none

module sis_cell (
   input  wire                     clock,
   input  wire sis_pkg::cell_ctrl_type ctrl,
   input  wire sis_pkg::value_type push_value,
   input  wire                     occupied,
   input  wire                     prev_keep,
   input  wire sis_pkg::value_type prev_value,
   input  wire sis_pkg::value_type next_value,
   output logic                    keep,
   output sis_pkg::value_type      value_out,
   output sis_pkg::value_type      value_next
);
   import sis_pkg::*;

   value_type value_ff;
   value_type value_in;

   // A cell keeps its value on a push when it holds something strictly
   // smaller than the incoming value, so an equal value lands nearer the top.
   assign keep = occupied && (value_ff < push_value);

   always_comb begin
      value_in = value_ff;
      if (ctrl.push) begin
         if (keep) begin
            value_in = value_ff;
         end else if (prev_keep) begin
            value_in = push_value;
         end else begin
            value_in = prev_value;
         end
      end else if (ctrl.pop) begin
         value_in = next_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value_out  = value_ff;
   assign value_next = value_in;

endmodule

`default_nettype wire

/* sv/sorted_insertion_stack.sv */
// Top level of the sorted insertion stack: controller, fill count and
// response register around a row of sis_cell instances. Depends on sis_pkg.
`default_nettype none

//  Channel | Direction | Ports                                  | Handshake
//  --------+-----------+----------------------------------------+-----------
//  req     | in        | req_opcode, req_value                  | valid/ready
//  rsp     | out       | rsp_top_value, rsp_count,              | valid/ready
//          |           | rsp_empty_res, rsp_status              |
//
// Each word's response is loaded into the response register at the edge that
// takes the word; a new word may be taken each cycle while responses drain.
// The rate is set by the row of cells, which compare against the pushed value
// in parallel and shift by one place in the same edge.
// A stalled response holds the register; the request side is then ready only
// in the cycle in which the waiting response is taken.
// Reset clears the fill count and the response valid flag; cell contents are
// left as they are, and a cell at or beyond the fill count is never read.

module sorted_insertion_stack (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire  [1:0]                   req_opcode,
   input  wire sis_pkg::value_type      req_value,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output sis_pkg::value_type           rsp_top_value,
   output logic [sis_pkg::COUNT_WIDTH-1:0] rsp_count,
   output logic                         rsp_empty_res,
   output logic [1:0]                   rsp_status
);
   import sis_pkg::*;

   logic                   accept;
   cell_ctrl_type          ctrl;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [1:0]             status_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   value_type              rsp_top_ff;
   logic [COUNT_WIDTH-1:0] rsp_count_ff;
   logic                   rsp_empty_ff;
   logic [1:0]             rsp_status_ff;

   logic      occupied   [DEPTH];
   logic      keep       [DEPTH];
   value_type cell_value [DEPTH];
   value_type cell_next  [DEPTH];

   // The single response register is free when empty or being drained.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // Decode the word into the shift command broadcast to every cell and
   // the new fill count. Full pushes and empty pops change nothing.
   always_comb begin
      ctrl      = '0;
      count_in  = count_ff;
      status_in = STATUS_OK;
      if (accept) begin
         unique case (req_opcode)
            OP_PUSH: begin
               if (count_ff == COUNT_WIDTH'(DEPTH)) begin
                  status_in = STATUS_OVERFLOW;
               end else begin
                  ctrl.push = 1'b1;
                  count_in  = count_ff + 1'b1;
               end
            end
            OP_POP: begin
               if (count_ff == '0) begin
                  status_in = STATUS_UNDERFLOW;
               end else begin
                  ctrl.pop = 1'b1;
                  count_in = count_ff - 1'b1;
               end
            end
            default: begin
               status_in = STATUS_OK;
            end
         endcase
      end
   end

   // Cell 0 holds the minimum; larger values sit further along the row.
   // A push opens a gap at the sorted place and the values not below it step
   // outwards, a pop draws every value one place towards cell 0.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      assign occupied[i] = count_ff > COUNT_WIDTH'(i);

      logic      prev_keep;
      value_type prev_value;
      value_type next_value;

      if (i == 0) begin : g_first
         assign prev_keep  = 1'b1;
         assign prev_value = req_value;
      end else begin : g_inner
         assign prev_keep  = keep[i-1];
         assign prev_value = cell_value[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign next_value = cell_value[i];
      end else begin : g_more
         assign next_value = cell_value[i+1];
      end

      sis_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .push_value (req_value),
         .occupied   (occupied[i]),
         .prev_keep  (prev_keep),
         .prev_value (prev_value),
         .next_value (next_value),
         .keep       (keep[i]),
         .value_out  (cell_value[i]),
         .value_next (cell_next[i])
      );
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The response reports the state after the operation, so it is taken
   // from the values the cells are about to load.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_top_ff    <= (count_in == '0) ? '0 : cell_next[0];
         rsp_count_ff  <= count_in;
         rsp_empty_ff  <= (count_in == '0);
         rsp_status_ff <= status_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_top_value = rsp_top_ff;
   assign rsp_count     = rsp_count_ff;
   assign rsp_empty_res = rsp_empty_ff;
   assign rsp_status    = rsp_status_ff;

   // The fill count never passes the depth of the row.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_WIDTH'(DEPTH))
      else $error("fill count beyond depth");

   // An accepted push with room grows the stack by exactly one.
   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      accept && req_opcode == OP_PUSH && count_ff != COUNT_WIDTH'(DEPTH)
      |=> count_ff == $past(count_ff) + 1'b1)
      else $error("push did not grow the stack");

   // Overflow is only reported with a full stack, underflow with an empty one.
   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == STATUS_OVERFLOW
      |-> rsp_count_ff == COUNT_WIDTH'(DEPTH))
      else $error("overflow reported below full");

   a_underflow_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == STATUS_UNDERFLOW |-> rsp_empty_ff)
      else $error("underflow reported on a non-empty stack");

   // The response register agrees with the live fill count when just loaded.
   a_rsp_count: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_count_ff == count_ff && rsp_empty_ff == (count_ff == '0))
      else $error("response count differs from fill count");

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for sorted_insertion_stack: a directed table of words followed
// by random phases, checked against pinned rows or a shadow model of the sorted stack.
// Depends on sis_pkg and the sorted_insertion_stack RTL.

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import sis_pkg::*;

   // The package names three operations; the fourth opcode is reserved and must behave
   // like a status read, so it gets a name of its own here.
   localparam logic [1:0] OP_SPARE = 2'd3;

   localparam value_type VALUE_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
   localparam value_type VALUE_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

   localparam int RANDOM_WORDS = 1400;
   // The final stretch of random words runs with both sides always willing.
   localparam int QUIET_FROM   = 1200;

   // One response word as the block reports it.
   typedef struct packed {
      value_type                top;
      logic [COUNT_WIDTH-1:0]   count;
      logic                     empty;
      logic [1:0]               status;
   } stack_view_type;

   // One row of the directed table. Where pinned is set the response is typed in
   // by hand; otherwise the shadow model supplies it.
   typedef struct {
      logic [1:0]     op;
      value_type      val;
      bit             pinned;
      stack_view_type want;
   } stim_row_type;

   typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED, PH_TIES} phase_kind_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [1:0]              req_opcode = OP_STATUS;
   value_type               req_value = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   value_type               rsp_top_value;
   logic [COUNT_WIDTH-1:0]  rsp_count;
   logic                    rsp_empty_res;
   logic [1:0]              rsp_status;

   // Shadow copy of the stack: cell 0 is the bottom, values never rise towards the top.
   value_type               shadow_cells [DEPTH];
   int                      shadow_fill = 0;

   stack_view_type          awaited_views [$];
   stim_row_type            directed_rows [$];
   stack_view_type          arrived_want;
   int                      mismatch_count = 0;
   bit                      idling_on = 1'b1;
   int                      ready_stall_left = 0;

   sorted_insertion_stack i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_opcode    (req_opcode),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_top_value (rsp_top_value),
      .rsp_count     (rsp_count),
      .rsp_empty_res (rsp_empty_res),
      .rsp_status    (rsp_status)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Apply one accepted word to the shadow stack and work out the response it must
   // produce. A push walks up from the bottom past every value greater than or equal to
   // the new one, so a value that ties with the top ends up on top. A push on a full
   // stack and a pop on an empty one leave the contents alone and only flag the fault.
   function automatic void predict_stack_view(input logic [1:0] op, input value_type v,
                                              output stack_view_type view);
      int pos;
      int i;
      view.status = STATUS_OK;
      case (op)
         OP_PUSH: begin
            if (shadow_fill >= DEPTH) begin
               view.status = STATUS_OVERFLOW;
            end else begin
               pos = 0;
               while (pos < shadow_fill && shadow_cells[pos] >= v) pos++;
               for (i = shadow_fill; i > pos; i--) shadow_cells[i] = shadow_cells[i-1];
               shadow_cells[pos] = v;
               shadow_fill++;
            end
         end
         OP_POP: begin
            if (shadow_fill == 0) view.status = STATUS_UNDERFLOW;
            else shadow_fill--;
         end
         default: ;  // status read and the reserved opcode change nothing
      endcase
      view.top   = (shadow_fill > 0) ? shadow_cells[shadow_fill-1] : '0;
      view.count = COUNT_WIDTH'(shadow_fill);
      view.empty = (shadow_fill == 0);
   endfunction

   // Values for the random part. Full-width random words exercise every bit; the narrow
   // band, the extremes and copies of stored values make ties and edge orderings common.
   function automatic value_type pick_value(input bit narrow);
      int sel;
      sel = narrow ? 1 : $urandom_range(0, 5);
      case (sel) inside
         0, 5: return value_type'($urandom);
         1:    return value_type'($urandom_range(0, 4)) - value_type'(2);
         2: begin
            case ($urandom_range(0, 3))
               0:       return VALUE_MIN;
               1:       return VALUE_MAX;
               2:       return '0;
               default: return '1;
            endcase
         end
         3: begin
            if (shadow_fill > 0) return shadow_cells[$urandom_range(0, shadow_fill-1)];
            return value_type'($urandom);
         end
         default: begin
            // Just either side of the current minimum, to probe the insertion boundary.
            if (shadow_fill > 0)
               return shadow_cells[shadow_fill-1] + value_type'($urandom_range(0, 2)) - 1;
            return value_type'($urandom);
         end
      endcase
   endfunction

   task automatic add_row(input logic [1:0] op, input value_type val, input bit pinned,
                          input value_type top, input int cnt, input bit emp,
                          input logic [1:0] st);
      stim_row_type row;
      row.op          = op;
      row.val         = val;
      row.pinned      = pinned;
      row.want.top    = top;
      row.want.count  = COUNT_WIDTH'(cnt);
      row.want.empty  = emp;
      row.want.status = st;
      directed_rows = {directed_rows, row};
   endtask

   // Offer one word and hold it steady until the block takes it. The shadow model is
   // stepped at the edge of acceptance, so its response is queued before the block's
   // own is taken and compared.
   task automatic send_word(input logic [1:0] op, input value_type v,
                            output stack_view_type predicted);
      int gap;
      if (idling_on && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 9);
         req_valid  <= 1'b0;
         req_opcode <= 2'($urandom);
         req_value  <= value_type'($urandom);
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_opcode <= op;
      req_value  <= v;
      do @(posedge clock); while (!req_ready);
      predict_stack_view(op, v, predicted);
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // Response side: every word taken is compared with the oldest outstanding expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_views.size() == 0) begin
            $display("%0t: response word with nothing expected, expected none, actual %0h",
                     $time, {rsp_top_value, rsp_count, rsp_empty_res, rsp_status});
            mismatch_count++;
         end else begin
            arrived_want = awaited_views.pop_front();
            check_field("top_value", 64'(arrived_want.top), 64'(rsp_top_value));
            check_field("count", 64'(arrived_want.count), 64'(rsp_count));
            check_field("empty_res", 64'(arrived_want.empty), 64'(rsp_empty_res));
            check_field("status", 64'(arrived_want.status), 64'(rsp_status));
         end
      end
   end

   // Back-pressure on the response side, in bursts. When idling is switched off the
   // current burst runs out and ready then stays high.
   always @(posedge clock) begin
      if (ready_stall_left > 0) begin
         rsp_ready <= 1'b0;
         ready_stall_left <= ready_stall_left - 1;
      end else if (idling_on && $urandom_range(0, 9) == 0) begin
         rsp_ready <= 1'b0;
         ready_stall_left <= $urandom_range(0, 8);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   initial begin
      int sent;
      int r;
      int phase_len;
      phase_kind_type phase_kind;
      logic [1:0] op;
      stack_view_type view;

      // The directed table. The first rows can be read straight off the behaviour: reads
      // and pops on the empty stack, the reserved opcode, the two extremes and a tie on
      // the minimum. The fill that follows is left to the shadow model; it ends in a push
      // on a full stack and is followed by a status read.
      add_row(OP_STATUS, '0,        1, '0,        0, 1, STATUS_OK);
      add_row(OP_POP,    '0,        1, '0,        0, 1, STATUS_UNDERFLOW);
      add_row(OP_SPARE,  VALUE_MAX, 1, '0,        0, 1, STATUS_OK);
      add_row(OP_PUSH,   VALUE_MAX, 1, VALUE_MAX, 1, 0, STATUS_OK);
      add_row(OP_PUSH,   VALUE_MIN, 1, VALUE_MIN, 2, 0, STATUS_OK);
      add_row(OP_PUSH,   VALUE_MIN, 1, VALUE_MIN, 3, 0, STATUS_OK);
      add_row(OP_POP,    '0,        1, VALUE_MIN, 2, 0, STATUS_OK);
      add_row(OP_POP,    '0,        1, VALUE_MAX, 1, 0, STATUS_OK);
      add_row(OP_PUSH,   -1,            0, '0, 0, 0, STATUS_OK);
      add_row(OP_PUSH,   1,             0, '0, 0, 0, STATUS_OK);
      add_row(OP_PUSH,   0,             0, '0, 0, 0, STATUS_OK);
      add_row(OP_PUSH,   100,           0, '0, 0, 0, STATUS_OK);
      add_row(OP_PUSH,   -100,          0, '0, 0, 0, STATUS_OK);
      add_row(OP_PUSH,   32'h4000_0000, 0, '0, 0, 0, STATUS_OK);
      add_row(OP_PUSH,   32'hc000_0000, 0, '0, 0, 0, STATUS_OK);
      add_row(OP_PUSH,   7,             0, '0, 0, 0, STATUS_OK);
      add_row(OP_PUSH,   7,             0, '0, 0, 0, STATUS_OK);
      add_row(OP_PUSH,   -7,            0, '0, 0, 0, STATUS_OK);
      add_row(OP_PUSH,   32'h0000_ffff, 0, '0, 0, 0, STATUS_OK);
      add_row(OP_PUSH,   32'hffff_0000, 0, '0, 0, 0, STATUS_OK);
      add_row(OP_PUSH,   32'h5555_5555, 0, '0, 0, 0, STATUS_OK);
      add_row(OP_PUSH,   32'haaaa_aaaa, 0, '0, 0, 0, STATUS_OK);
      add_row(OP_PUSH,   2,             0, '0, 0, 0, STATUS_OK);
      add_row(OP_PUSH,   3,             0, '0, 0, 0, STATUS_OK);
      add_row(OP_STATUS, VALUE_MIN,     0, '0, 0, 0, STATUS_OK);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[k]) begin
         send_word(directed_rows[k].op, directed_rows[k].val, view);
         awaited_views = {awaited_views,
                          (directed_rows[k].pinned ? directed_rows[k].want : view)};
      end

      // Random phases. Filling and draining phases drive the stack against both walls
      // repeatedly; the tie phase keeps values in a narrow band so that equal values meet
      // often. Idling is switched on for most phases and off in the closing stretch.
      sent = 0;
      while (sent < RANDOM_WORDS) begin
         phase_kind = phase_kind_type'($urandom_range(0, 3));
         phase_len  = $urandom_range(8, 64);
         idling_on  = (sent < QUIET_FROM) && ($urandom_range(0, 3) != 0);
         repeat (phase_len) begin
            r = $urandom_range(0, 99);
            case (phase_kind)
               PH_FILL:  op = (r < 85) ? OP_PUSH : (r < 95) ? OP_POP :
                              (r < 98) ? OP_STATUS : OP_SPARE;
               PH_DRAIN: op = (r < 85) ? OP_POP : (r < 93) ? OP_PUSH :
                              (r < 97) ? OP_STATUS : OP_SPARE;
               default:  op = (r < 45) ? OP_PUSH : (r < 90) ? OP_POP :
                              (r < 95) ? OP_STATUS : OP_SPARE;
            endcase
            send_word(op, pick_value(phase_kind == PH_TIES), view);
            awaited_views = {awaited_views, view};
            sent++;
         end
      end

      idling_on = 1'b0;
      req_valid <= 1'b0;
      while (awaited_views.size() != 0) @(posedge clock);
      // Keep clocking so that a stray extra response would still be caught.
      repeat (4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest legal run with every gap and stall at its longest.
   initial begin
      #3_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
